FILE: src/gcvs_pkg.sv
// gcvs_pkg: shared types, codes and defaults of the gc victim selector
// no dependencies; used by gc_victim_selector_top
package gcvs_pkg;

  localparam int SEG_W   = 10;
  localparam int CTL_W   = 8;
  localparam int CNT_W   = 13;
  localparam int FREE_W  = 16;
  localparam int SUM_W   = 32;
  localparam int SEG_IDS = 1024;

  localparam int DEF_NUM_SEGMENTS = 1024;
  localparam int DEF_SCAN_WINDOW  = 1024;
  localparam int DEF_MAX_GRAINS   = 4096;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_INVAL  = 2'd1,
    MODE_POLL   = 2'd2,
    MODE_FINISH = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_CHOSEN   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RELEASED = 3'd3,
    ST_REQUEUED = 3'd4,
    ST_IDLE_GC  = 3'd5,
    ST_BUSY     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    REG_POLICY = 2'd0,
    REG_LOW_WM = 2'd1,
    REG_HIGH_WM = 2'd2,
    REG_GRAINS = 2'd3
  } reg_index_t;

  localparam logic [CNT_W-1:0]  RST_GRAINS  = 13'd4096;
  localparam logic [FREE_W-1:0] RST_LOW_WM  = 16'd16;
  localparam logic [FREE_W-1:0] RST_HIGH_WM = 16'd64;

endpackage

FILE: src/gc_victim_selector_top.sv
// gc_victim_selector_top: greedy-window / circular gc victim selection
// depends on gcvs_pkg; queue, valid counts and owners live in on-chip memories
//
// channel  | handshake           | payload
// ---------+---------------------+----------------------------------------------
// command  | start / busy        | mode, segment_id, controller_id, initial_valid,
//          |                     | invalid_grains, free_segments, reloc_ok,
//          |                     | pages_relocated
// result   | done (one cycle)    | status, victim_segment, victim_controller,
//          |                     | victim_valid, total_page_relocs
// config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// write, watermark-only poll and finish with no data: result from S_IDLE
// invalidate: via S_INV; finish with a segment: via S_EMIT
// circular poll: S_HEAD, S_INFO, S_EMIT; greedy poll: pipelined S_SCAN of up to
//   SCAN_WINDOW+1 entries, one-entry-per-cycle order memory compaction, S_EMIT
// reset is synchronous; memories are not cleared, the queue starts empty
// the receiver cannot stall; busy covers all multi-cycle work
module gc_victim_selector_top #(
  parameter int NUM_SEGMENTS = gcvs_pkg::DEF_NUM_SEGMENTS,
  parameter int SCAN_WINDOW  = gcvs_pkg::DEF_SCAN_WINDOW,
  parameter int MAX_GRAINS   = gcvs_pkg::DEF_MAX_GRAINS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   mode,
  input  logic [gcvs_pkg::SEG_W-1:0]   segment_id,
  input  logic [gcvs_pkg::CTL_W-1:0]   controller_id,
  input  logic [gcvs_pkg::CNT_W-1:0]   initial_valid,
  input  logic [gcvs_pkg::CNT_W-1:0]   invalid_grains,
  input  logic [gcvs_pkg::FREE_W-1:0]  free_segments,
  input  logic                         reloc_ok,
  input  logic [gcvs_pkg::CNT_W-1:0]   pages_relocated,
  output logic                         done,
  output logic [2:0]                   status,
  output logic [gcvs_pkg::SEG_W-1:0]   victim_segment,
  output logic [gcvs_pkg::CTL_W-1:0]   victim_controller,
  output logic [gcvs_pkg::CNT_W-1:0]   victim_valid,
  output logic [gcvs_pkg::SUM_W-1:0]   total_page_relocs,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [gcvs_pkg::FREE_W-1:0]  cfg_data
);

  localparam int SEG_W = gcvs_pkg::SEG_W;
  localparam int CTL_W = gcvs_pkg::CTL_W;
  localparam int CNT_W = gcvs_pkg::CNT_W;
  localparam int IW    = $clog2(NUM_SEGMENTS);
  localparam int IW1   = IW + 1;
  localparam int LW    = $clog2(NUM_SEGMENTS + 1);
  localparam int BW    = CNT_W + 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INV   = 7'b0000010,
    S_HEAD  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_SHIFT = 7'b0010000,
    S_INFO  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  // circular queue slot of an offset from the head
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base,
                                         input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= IW1'(NUM_SEGMENTS)) s = s - IW1'(NUM_SEGMENTS);
    return s[IW-1:0];
  endfunction

  // configuration registers
  logic                     policy;
  logic [15:0]              low_wm;
  logic [15:0]              high_wm;
  logic [CNT_W-1:0]         grains;

  // control state
  state_t                   state;
  logic [IW-1:0]            head;
  logic [LW-1:0]            qlen;
  logic                     collecting;
  logic                     victim_pending;
  logic [SEG_W-1:0]         pend_seg;
  logic [gcvs_pkg::SUM_W-1:0] relocated_sum;

  // working registers
  logic [SEG_W-1:0]         inv_seg;
  logic [CNT_W-1:0]         inv_amt;
  logic [2:0]               emit_code;
  logic [IW-1:0]            iss;
  logic                     issue_on;
  logic [IW-1:0]            scan_last;
  logic                     v1, v2;
  logic [IW-1:0]            i1, i2;
  logic [SEG_W-1:0]         s2;
  logic [BW-1:0]            best;
  logic [IW-1:0]            best_pos;
  logic [SEG_W-1:0]         min_seg;
  logic                     found;
  logic [IW-1:0]            sh_rd;
  logic                     sh_on;
  logic                     sh_wv;
  logic [IW-1:0]            sh_woff;

  // memories
  logic [SEG_W-1:0]         order_mem [NUM_SEGMENTS];
  logic [CNT_W-1:0]         vc_mem    [gcvs_pkg::SEG_IDS];
  logic [CTL_W-1:0]         own_mem   [gcvs_pkg::SEG_IDS];
  logic [SEG_W-1:0]         order_rdata;
  logic [CNT_W-1:0]         vc_rdata;
  logic [CTL_W-1:0]         own_rdata;
  logic [IW-1:0]            order_raddr;
  logic [SEG_W-1:0]         vc_raddr;
  logic                     order_we;
  logic [IW-1:0]            order_waddr;
  logic [SEG_W-1:0]         order_wdata;
  logic                     vc_we;
  logic [SEG_W-1:0]         vc_waddr;
  logic [CNT_W-1:0]         vc_wdata;
  logic                     own_we;

  logic                     accept;
  logic [CNT_W-1:0]         bound;
  logic [CNT_W-1:0]         init_clamped;
  logic                     coll_next;
  logic                     q_full;
  logic [IW-1:0]            head_inc;
  logic [IW-1:0]            head_dec;
  logic [IW-1:0]            tail;
  logic [LW-1:0]            len_m1;
  logic [32:0]              sum_add;
  logic [IW-1:0]            sh_waddr;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign total_page_relocs = relocated_sum;

  // derived values
  always_comb begin
    bound = ({4'b0, grains} > 17'(MAX_GRAINS)) ? CNT_W'(MAX_GRAINS) : grains;
    init_clamped = (initial_valid > bound) ? bound : initial_valid;
    coll_next = (collecting || (free_segments <= low_wm)) && !(free_segments >= high_wm);
    q_full   = (qlen >= LW'(NUM_SEGMENTS));
    head_inc = (head == IW'(NUM_SEGMENTS - 1)) ? '0 : head + 1'b1;
    head_dec = (head == '0) ? IW'(NUM_SEGMENTS - 1) : head - 1'b1;
    tail     = phys(head, qlen[IW-1:0]);
    len_m1   = qlen - 1'b1;
    sum_add  = {1'b0, relocated_sum} + 33'(pages_relocated);
    sh_waddr = phys(head, sh_woff);
  end

  // memory address and write control
  always_comb begin
    order_raddr = head;
    vc_raddr    = pend_seg;
    order_we    = 1'b0;
    order_waddr = tail;
    order_wdata = segment_id;
    vc_we       = 1'b0;
    vc_waddr    = segment_id;
    vc_wdata    = init_clamped;
    own_we      = 1'b0;
    case (state)
      S_IDLE: begin
        if (mode == gcvs_pkg::MODE_INVAL) vc_raddr = segment_id;
        if (accept && mode == gcvs_pkg::MODE_WRITE && !q_full) begin
          order_we = 1'b1;
          vc_we    = 1'b1;
          own_we   = 1'b1;
        end
        if (accept && mode == gcvs_pkg::MODE_FINISH && victim_pending && !reloc_ok
            && !q_full) begin
          order_we    = 1'b1;
          order_waddr = policy ? head_dec : tail;
          order_wdata = pend_seg;
        end
      end
      S_INV: begin
        vc_we    = 1'b1;
        vc_waddr = inv_seg;
        vc_wdata = (inv_amt >= vc_rdata) ? '0 : vc_rdata - inv_amt;
      end
      S_SCAN: begin
        order_raddr = phys(head, iss);
        vc_raddr    = order_rdata;
      end
      S_SHIFT: begin
        order_raddr = phys(head, sh_rd);
        order_we    = sh_wv;
        order_waddr = sh_waddr;
        order_wdata = order_rdata;
      end
      default: ;
    endcase
  end

  // synchronous memories, registered read data
  always_ff @(posedge clk) begin
    if (order_we) order_mem[order_waddr] <= order_wdata;
    if (vc_we) vc_mem[vc_waddr] <= vc_wdata;
    if (own_we) own_mem[segment_id] <= controller_id;
    order_rdata <= order_mem[order_raddr];
    vc_rdata    <= vc_mem[vc_raddr];
    own_rdata   <= own_mem[pend_seg];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      policy  <= 1'b1;
      low_wm  <= gcvs_pkg::RST_LOW_WM;
      high_wm <= gcvs_pkg::RST_HIGH_WM;
      grains  <= gcvs_pkg::RST_GRAINS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gcvs_pkg::REG_POLICY:  policy  <= cfg_data[0];
        gcvs_pkg::REG_LOW_WM:  low_wm  <= cfg_data;
        gcvs_pkg::REG_HIGH_WM: high_wm <= cfg_data;
        gcvs_pkg::REG_GRAINS:  grains  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      head           <= '0;
      qlen           <= '0;
      collecting     <= 1'b0;
      victim_pending <= 1'b0;
      pend_seg       <= '0;
      relocated_sum  <= '0;
      done           <= 1'b0;
      issue_on       <= 1'b0;
      v1             <= 1'b0;
      v2             <= 1'b0;
      sh_on          <= 1'b0;
      sh_wv          <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            status            <= gcvs_pkg::ST_ACCEPTED;
            victim_segment    <= '0;
            victim_controller <= '0;
            victim_valid      <= '0;
            case (mode)
              gcvs_pkg::MODE_WRITE: begin
                done <= 1'b1;
                if (q_full) status <= gcvs_pkg::ST_BUSY;
                else qlen <= qlen + 1'b1;
              end
              gcvs_pkg::MODE_INVAL: begin
                inv_seg <= segment_id;
                inv_amt <= invalid_grains;
                state   <= S_INV;
              end
              gcvs_pkg::MODE_POLL: begin
                collecting <= coll_next;
                if (!coll_next) begin
                  done <= 1'b1; status <= gcvs_pkg::ST_IDLE_GC;
                end else if (victim_pending) begin
                  done <= 1'b1; status <= gcvs_pkg::ST_BUSY;
                end else if (qlen == '0) begin
                  done <= 1'b1; status <= gcvs_pkg::ST_EMPTY;
                end else if (!policy) begin
                  state <= S_HEAD;
                end else begin
                  iss      <= '0;
                  issue_on <= 1'b1;
                  v1       <= 1'b0;
                  v2       <= 1'b0;
                  found    <= 1'b0;
                  best     <= {1'b0, bound} + 1'b1;
                  best_pos <= '0;
                  scan_last <= (32'(len_m1) > 32'(SCAN_WINDOW)) ? IW'(SCAN_WINDOW)
                                                               : len_m1[IW-1:0];
                  state    <= S_SCAN;
                end
              end
              default: begin
                if (!victim_pending || (!reloc_ok && q_full)) begin
                  done <= 1'b1; status <= gcvs_pkg::ST_BUSY;
                end else begin
                  relocated_sum  <= sum_add[32] ? '1 : sum_add[31:0];
                  victim_pending <= 1'b0;
                  if (reloc_ok) begin
                    emit_code <= gcvs_pkg::ST_RELEASED;
                  end else begin
                    emit_code <= gcvs_pkg::ST_REQUEUED;
                    qlen      <= qlen + 1'b1;
                    if (policy) head <= head_dec;
                  end
                  state <= S_EMIT;
                end
              end
            endcase
          end
        end
        S_INV: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_HEAD: begin
          pend_seg  <= order_rdata;
          head      <= head_inc;
          qlen      <= len_m1;
          emit_code <= gcvs_pkg::ST_CHOSEN;
          state     <= S_INFO;
        end
        S_SCAN: begin
          // three-stage scan: queue slot, valid count, compare
          v1 <= issue_on;
          i1 <= iss;
          v2 <= v1;
          i2 <= i1;
          s2 <= order_rdata;
          if (issue_on) begin
            if (iss == scan_last) issue_on <= 1'b0;
            else iss <= iss + 1'b1;
          end
          if (v2 && ({1'b0, vc_rdata} < best)) begin
            best     <= {1'b0, vc_rdata};
            best_pos <= i2;
            min_seg  <= s2;
            found    <= 1'b1;
          end
          if (!issue_on && !v1 && !v2) begin
            if (!found) begin
              done   <= 1'b1;
              status <= gcvs_pkg::ST_BUSY;
              state  <= S_IDLE;
            end else begin
              pend_seg  <= min_seg;
              emit_code <= gcvs_pkg::ST_CHOSEN;
              if (best_pos == '0) begin
                head  <= head_inc;
                qlen  <= len_m1;
                state <= S_INFO;
              end else begin
                sh_rd <= best_pos - 1'b1;
                sh_on <= 1'b1;
                sh_wv <= 1'b0;
                state <= S_SHIFT;
              end
            end
          end
        end
        S_SHIFT: begin
          // move entries ahead of the victim one slot toward the tail
          sh_wv   <= sh_on;
          sh_woff <= sh_rd + 1'b1;
          if (sh_on) begin
            if (sh_rd == '0) sh_on <= 1'b0;
            else sh_rd <= sh_rd - 1'b1;
          end
          if (!sh_on && !sh_wv) begin
            head  <= head_inc;
            qlen  <= len_m1;
            state <= S_INFO;
          end
        end
        S_INFO: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          done              <= 1'b1;
          status            <= emit_code;
          victim_segment    <= pend_seg;
          victim_controller <= own_rdata;
          victim_valid      <= vc_rdata;
          if (emit_code == gcvs_pkg::ST_CHOSEN) victim_pending <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // queue never grows past its capacity
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    qlen <= LW'(NUM_SEGMENTS))
    else $error("queue length beyond capacity");

  // a chosen victim is always marked outstanding afterwards
  a_chosen_pending: assert property (@(posedge clk) disable iff (rst)
    (done && status == gcvs_pkg::ST_CHOSEN) |-> victim_pending)
    else $error("victim chosen but not outstanding");

  // every result follows an accepted command or internal work
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept || busy))
    else $error("result without a transaction");

  // release or requeue clears the outstanding victim
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    (done && (status == gcvs_pkg::ST_RELEASED || status == gcvs_pkg::ST_REQUEUED))
      |-> !victim_pending)
    else $error("victim still outstanding after finish");

endmodule
